// File: hw/rtl/cartesian_to_spherical_defines.svh
// Assertion macros for the cartesian to spherical converter.
// Needs nothing else; included by the top level only.
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// check a condition in the same cycle
`define C2S_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("c2s: same-cycle check failed");

// check a condition in the next cycle
`define C2S_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("c2s: next-cycle check failed");

`endif

// File: hw/rtl/c2s_pkg.sv
// Shared types, constants and elaboration-time functions of the converter.
// Used by every module of the block but the square-root cell; depends on nothing.
`default_nettype none

package c2s_pkg;

    localparam int COORD_BITS    = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int THR_BITS      = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int TURN_BITS     = 64;
    localparam int CORDIC_STAGES = 62;
    localparam int NORM_STEPS    = 8;
    localparam int POLAR_SHIFT   = 15;
    localparam int PL_SHIFT      = 30;

    localparam logic [APB_ADDR_BITS-3:0] REG_ZERO_THRESHOLD = '0;

    localparam logic [TURN_BITS-1:0] TURN_QUARTER  = 64'h1000_0000_0000_0000;
    localparam logic [TURN_BITS-1:0] TURN_HALF     = 64'h2000_0000_0000_0000;
    localparam logic [TURN_BITS-1:0] TURN_3QUARTER = 64'h3000_0000_0000_0000;
    localparam logic [TURN_BITS-1:0] TURN_FULL     = 64'h4000_0000_0000_0000;
    localparam logic [TURN_BITS-1:0] TURN_EIGHTH   = 64'h0800_0000_0000_0000;
    localparam logic [TURN_BITS-1:0] PI_Q60        = 64'h3243_F6A8_885A_308D;

    localparam logic [ANGLE_BITS-1:0] UNITS_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    typedef enum logic [1:0] {
        SIDE_ZERO,
        SIDE_POS,
        SIDE_NEG
    } side_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic signed [COORD_BITS-1:0] z_coord;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] radius;
        logic [ANGLE_BITS-1:0] polar_angle;
        logic [ANGLE_BITS-1:0] azimuth;
        logic                  undefined_flag;
    } out_word_t;

    typedef struct packed {
        side_t side_x;
        side_t side_y;
        side_t side_z;
        logic  zero_all;
        logic  pl_zero;
    } meta_t;

    function automatic logic [63:0] udiv_low(input logic [127:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 127; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-idx) in turns, 2^62 per turn, rounded to nearest
    function automatic logic [63:0] atan_entry(input int idx);
        logic [63:0]  rad;
        logic [63:0]  term;
        logic [127:0] num;
        int           k;
        int           e;
        rad = '0;
        if (idx == 0) begin
            return TURN_EIGHTH;
        end
        for (k = 0; k < 31; k++) begin
            e = idx * (2 * k + 1);
            if (e <= 60) begin
                term = udiv_low(128'(64'h1 << (60 - e)), 64'(2 * k + 1));
                if (k[0]) begin
                    rad = rad - term;
                end else begin
                    rad = rad + term;
                end
            end
        end
        num = {2'b00, rad, 62'b0} + {64'b0, PI_Q60};
        return udiv_low(num, {PI_Q60[62:0], 1'b0});
    endfunction

    function automatic logic [TURN_BITS-1:0] clamp_turn(input logic [TURN_BITS-1:0] z);
        if (z[TURN_BITS-1]) begin
            return '0;
        end
        return (z > TURN_QUARTER) ? TURN_QUARTER : z;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] to_units(input logic [TURN_BITS-1:0] a);
        logic [TURN_BITS-1:0] sum;
        sum = a + (TURN_BITS'(1) << (61 - ANGLE_BITS));
        return sum[61 -: ANGLE_BITS];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cartesian_to_spherical.sv
// Top level of the cartesian to spherical converter and its register port.
// Depends on c2s_pkg, c2s_sqrt_cell, c2s_norm_cell, c2s_cordic_cell and the defines header.
// Fully pipelined: one vector is accepted per cycle unless the output stalls; its result
// passes 3 front stages, 47 square-root digit cells, 1 rounding stage, 8 normaliser cells,
// 62 CORDIC cells and 1 output register. The CORDIC chain sets the depth. The whole
// pipeline holds while a result waits on m_ready, so input is taken whenever the output
// register is empty or being read. The user must write zero_threshold through the APB
// port at address 0 only while no vectors are in flight; the block does not enforce it.
`default_nettype none
`include "cartesian_to_spherical_defines.svh"

module cartesian_to_spherical (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire c2s_pkg::in_word_t                     s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output c2s_pkg::out_word_t                         m_data,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [c2s_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [c2s_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic      [c2s_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                       pready
);

    import c2s_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int K_SQ   = CB + POLAR_SHIFT;
    localparam int NW_RHO = 2 * CB + PL_SHIFT;
    localparam int NW_RAD = 2 * CB;
    localparam int DEPTH  = 3 + K_SQ + 1 + NORM_STEPS + CORDIC_STAGES + 1;

    logic                en;
    logic [DEPTH-1:0]    vld_reg;
    logic [THR_BITS-1:0] thr_reg;
    logic                reg_hit;

    // register port
    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_BITS-1:2] == REG_ZERO_THRESHOLD;
    assign prdata  = reg_hit ? APB_DATA_BITS'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            thr_reg <= pwdata[THR_BITS-1:0];
        end
    end

    // advance the whole pipe unless a result is held
    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // front: magnitudes and sides
    logic [CB-1:0] in_mag_x;
    logic [CB-1:0] in_mag_y;
    logic [CB-1:0] in_mag_z;
    logic [CB-1:0] a_mx_reg;
    logic [CB-1:0] a_my_reg;
    logic [CB-1:0] a_mz_reg;
    meta_t         a_meta_reg;

    assign in_mag_x = s_data.x_coord[CB-1] ? (~s_data.x_coord + 1'b1) : s_data.x_coord;
    assign in_mag_y = s_data.y_coord[CB-1] ? (~s_data.y_coord + 1'b1) : s_data.y_coord;
    assign in_mag_z = s_data.z_coord[CB-1] ? (~s_data.z_coord + 1'b1) : s_data.z_coord;

    function automatic side_t side_of(input logic [CB-1:0] mag, input logic neg,
                                      input logic [THR_BITS-1:0] thr);
        if (mag == '0 || mag < CB'(thr)) begin
            return SIDE_ZERO;
        end
        return neg ? SIDE_NEG : SIDE_POS;
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mx_reg            <= in_mag_x;
            a_my_reg            <= in_mag_y;
            a_mz_reg            <= in_mag_z;
            a_meta_reg.side_x   <= side_of(in_mag_x, s_data.x_coord[CB-1], thr_reg);
            a_meta_reg.side_y   <= side_of(in_mag_y, s_data.y_coord[CB-1], thr_reg);
            a_meta_reg.side_z   <= side_of(in_mag_z, s_data.z_coord[CB-1], thr_reg);
            a_meta_reg.zero_all <= (in_mag_x | in_mag_y | in_mag_z) == '0;
            a_meta_reg.pl_zero  <= 1'b0;
        end
    end

    // squares
    logic [NW_RAD-1:0] b_sqx_reg;
    logic [NW_RAD-1:0] b_sqy_reg;
    logic [NW_RAD-1:0] b_sqz_reg;
    logic [CB-1:0]     b_mx_reg;
    logic [CB-1:0]     b_my_reg;
    logic [CB-1:0]     b_mz_reg;
    meta_t             b_meta_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sqx_reg  <= NW_RAD'(a_mx_reg) * NW_RAD'(a_mx_reg);
            b_sqy_reg  <= NW_RAD'(a_my_reg) * NW_RAD'(a_my_reg);
            b_sqz_reg  <= NW_RAD'(a_mz_reg) * NW_RAD'(a_mz_reg);
            b_mx_reg   <= a_mx_reg;
            b_my_reg   <= a_my_reg;
            b_mz_reg   <= a_mz_reg;
            b_meta_reg <= a_meta_reg;
        end
    end

    // square root chain: in-plane (scaled) and full radius side by side
    logic [NW_RAD-1:0] pl_sum;
    meta_t             b_meta_pl;
    logic [NW_RHO-1:0] rho_rem_reg  [K_SQ+1];
    logic [K_SQ-1:0]   rho_root_reg [K_SQ+1];
    logic [NW_RAD-1:0] rad_rem_reg  [K_SQ+1];
    logic [CB-1:0]     rad_root_reg [K_SQ+1];
    logic [CB-1:0]     sq_mx_reg    [K_SQ+1];
    logic [CB-1:0]     sq_my_reg    [K_SQ+1];
    logic [CB-1:0]     sq_mz_reg    [K_SQ+1];
    meta_t             sq_meta_reg  [K_SQ+1];

    assign pl_sum = b_sqx_reg + b_sqy_reg;

    always_comb begin
        b_meta_pl         = b_meta_reg;
        b_meta_pl.pl_zero = pl_sum == '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rho_rem_reg[0]      <= {pl_sum, PL_SHIFT'(0)};
            rho_root_reg[0]     <= '0;
            rad_rem_reg[0]      <= pl_sum + b_sqz_reg;
            rad_root_reg[0]     <= '0;
            sq_mx_reg[0]        <= b_mx_reg;
            sq_my_reg[0]        <= b_my_reg;
            sq_mz_reg[0]        <= b_mz_reg;
            sq_meta_reg[0]      <= b_meta_pl;
        end
    end

    for (genvar k = 0; k < K_SQ; k++) begin : g_sqrt
        c2s_sqrt_cell #(
            .NW (NW_RHO),
            .RW (K_SQ),
            .BIT(K_SQ - 1 - k)
        ) u_rho (
            .aclk    (aclk),
            .en      (en),
            .rem_in  (rho_rem_reg[k]),
            .root_in (rho_root_reg[k]),
            .rem_out (rho_rem_reg[k+1]),
            .root_out(rho_root_reg[k+1])
        );

        if (k >= K_SQ - CB) begin : g_rad
            c2s_sqrt_cell #(
                .NW (NW_RAD),
                .RW (CB),
                .BIT(K_SQ - 1 - k)
            ) u_rad (
                .aclk    (aclk),
                .en      (en),
                .rem_in  (rad_rem_reg[k]),
                .root_in (rad_root_reg[k]),
                .rem_out (rad_rem_reg[k+1]),
                .root_out(rad_root_reg[k+1])
            );
        end else begin : g_rad_hold
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_rem_reg[k+1]  <= rad_rem_reg[k];
                    rad_root_reg[k+1] <= rad_root_reg[k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_mx_reg[k+1]   <= sq_mx_reg[k];
                sq_my_reg[k+1]   <= sq_my_reg[k];
                sq_mz_reg[k+1]   <= sq_mz_reg[k];
                sq_meta_reg[k+1] <= sq_meta_reg[k];
            end
        end
    end

    // round radius, load normaliser operands
    logic [TURN_BITS-1:0] npp_reg [NORM_STEPS+1];
    logic [TURN_BITS-1:0] npq_reg [NORM_STEPS+1];
    logic [TURN_BITS-1:0] nap_reg [NORM_STEPS+1];
    logic [TURN_BITS-1:0] naq_reg [NORM_STEPS+1];
    logic [CB-1:0]        nr_reg  [NORM_STEPS+1];
    meta_t                nm_reg  [NORM_STEPS+1];
    logic                 rad_up;

    assign rad_up = rad_rem_reg[K_SQ] > NW_RAD'(rad_root_reg[K_SQ]);

    always_ff @(posedge aclk) begin
        if (en) begin
            nr_reg[0]  <= rad_up ? CB'(rad_root_reg[K_SQ] + 1'b1) : rad_root_reg[K_SQ];
            npp_reg[0] <= TURN_BITS'({sq_mz_reg[K_SQ], POLAR_SHIFT'(0)});
            npq_reg[0] <= TURN_BITS'(rho_root_reg[K_SQ]);
            nap_reg[0] <= TURN_BITS'(sq_mx_reg[K_SQ]);
            naq_reg[0] <= TURN_BITS'(sq_my_reg[K_SQ]);
            nm_reg[0]  <= sq_meta_reg[K_SQ];
        end
    end

    // two right steps bring wide operands under 2^60, six left steps lift them to 2^59
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam bit RIGHT = j < 2;
        localparam int SHIFT = (j < 2) ? (2 - j) : (1 << (NORM_STEPS - 1 - j));

        c2s_norm_cell #(.SHIFT(SHIFT), .RIGHT(RIGHT)) u_pol (
            .aclk (aclk),
            .en   (en),
            .p_in (npp_reg[j]),
            .q_in (npq_reg[j]),
            .p_out(npp_reg[j+1]),
            .q_out(npq_reg[j+1])
        );

        c2s_norm_cell #(.SHIFT(SHIFT), .RIGHT(RIGHT)) u_azi (
            .aclk (aclk),
            .en   (en),
            .p_in (nap_reg[j]),
            .q_in (naq_reg[j]),
            .p_out(nap_reg[j+1]),
            .q_out(naq_reg[j+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                nr_reg[j+1] <= nr_reg[j];
                nm_reg[j+1] <= nm_reg[j];
            end
        end
    end

    // CORDIC chains
    logic [TURN_BITS-1:0] cpx_reg [CORDIC_STAGES];
    logic [TURN_BITS-1:0] cpy_reg [CORDIC_STAGES];
    logic [TURN_BITS-1:0] cpz_reg [CORDIC_STAGES];
    logic [TURN_BITS-1:0] cax_reg [CORDIC_STAGES];
    logic [TURN_BITS-1:0] cay_reg [CORDIC_STAGES];
    logic [TURN_BITS-1:0] caz_reg [CORDIC_STAGES];
    logic [CB-1:0]        cr_reg  [CORDIC_STAGES];
    meta_t                cm_reg  [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        if (s == 0) begin : g_first
            c2s_cordic_cell #(.STAGE(s)) u_pol (
                .aclk (aclk),
                .en   (en),
                .x_in (npp_reg[NORM_STEPS]),
                .y_in (npq_reg[NORM_STEPS]),
                .z_in ('0),
                .x_out(cpx_reg[s]),
                .y_out(cpy_reg[s]),
                .z_out(cpz_reg[s])
            );
            c2s_cordic_cell #(.STAGE(s)) u_azi (
                .aclk (aclk),
                .en   (en),
                .x_in (nap_reg[NORM_STEPS]),
                .y_in (naq_reg[NORM_STEPS]),
                .z_in ('0),
                .x_out(cax_reg[s]),
                .y_out(cay_reg[s]),
                .z_out(caz_reg[s])
            );
            always_ff @(posedge aclk) begin
                if (en) begin
                    cr_reg[s] <= nr_reg[NORM_STEPS];
                    cm_reg[s] <= nm_reg[NORM_STEPS];
                end
            end
        end else begin : g_next
            c2s_cordic_cell #(.STAGE(s)) u_pol (
                .aclk (aclk),
                .en   (en),
                .x_in (cpx_reg[s-1]),
                .y_in (cpy_reg[s-1]),
                .z_in (cpz_reg[s-1]),
                .x_out(cpx_reg[s]),
                .y_out(cpy_reg[s]),
                .z_out(cpz_reg[s])
            );
            c2s_cordic_cell #(.STAGE(s)) u_azi (
                .aclk (aclk),
                .en   (en),
                .x_in (cax_reg[s-1]),
                .y_in (cay_reg[s-1]),
                .z_in (caz_reg[s-1]),
                .x_out(cax_reg[s]),
                .y_out(cay_reg[s]),
                .z_out(caz_reg[s])
            );
            always_ff @(posedge aclk) begin
                if (en) begin
                    cr_reg[s] <= cr_reg[s-1];
                    cm_reg[s] <= cm_reg[s-1];
                end
            end
        end
    end

    // quadrant mapping and output register
    meta_t                fm;
    logic [TURN_BITS-1:0] pol_a;
    logic [TURN_BITS-1:0] azi_a;
    logic [TURN_BITS-1:0] pol_t;
    logic [TURN_BITS-1:0] azi_t;
    out_word_t            out_next;
    out_word_t            out_reg;

    assign fm    = cm_reg[CORDIC_STAGES-1];
    assign pol_a = fm.pl_zero ? '0 : clamp_turn(cpz_reg[CORDIC_STAGES-1]);
    assign azi_a = clamp_turn(caz_reg[CORDIC_STAGES-1]);

    always_comb begin
        case (fm.side_z)
            SIDE_POS: pol_t = pol_a;
            SIDE_NEG: pol_t = TURN_HALF - pol_a;
            default:  pol_t = TURN_QUARTER;
        endcase

        if (fm.side_y == SIDE_ZERO) begin
            azi_t = (fm.side_x == SIDE_POS) ? TURN_HALF : '0;
        end else if (fm.side_x == SIDE_ZERO) begin
            azi_t = (fm.side_y == SIDE_POS) ? TURN_QUARTER : TURN_3QUARTER;
        end else if (fm.side_x == SIDE_NEG && fm.side_y == SIDE_POS) begin
            azi_t = azi_a;
        end else if (fm.side_y == SIDE_POS) begin
            azi_t = TURN_HALF - azi_a;
        end else if (fm.side_x == SIDE_POS) begin
            azi_t = TURN_HALF + azi_a;
        end else begin
            azi_t = TURN_FULL - azi_a;
        end

        if (fm.zero_all) begin
            out_next.radius         = '0;
            out_next.polar_angle    = '0;
            out_next.azimuth        = '0;
            out_next.undefined_flag = 1'b1;
        end else begin
            out_next.radius         = cr_reg[CORDIC_STAGES-1];
            out_next.polar_angle    = to_units(pol_t);
            out_next.azimuth        = to_units(azi_t);
            out_next.undefined_flag = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    `C2S_ASSERT_NOW(a_undef_zero, aclk, aresetn, m_valid && m_data.undefined_flag, m_data.radius == '0 && m_data.polar_angle == '0 && m_data.azimuth == '0)
    `C2S_ASSERT_NOW(a_polar_range, aclk, aresetn, m_valid, m_data.polar_angle <= UNITS_HALF)
    `C2S_ASSERT_NEXT(a_pipe_hold, aclk, aresetn, m_valid && !m_ready, $stable(vld_reg))

endmodule

`default_nettype wire

// File: hw/rtl/c2s_sqrt_cell.sv
// One digit cell of the pipelined restoring square root.
// Uses nothing from the package; instantiated by the top level.
`default_nettype none

module c2s_sqrt_cell #(
    parameter int NW  = 64,
    parameter int RW  = 32,
    parameter int BIT = 0
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    output logic      [NW-1:0] rem_out,
    output logic      [RW-1:0] root_out
);

    localparam int TW = 2 * RW + 2;

    logic [TW-1:0] rem_ext;
    logic [TW-1:0] trial;
    logic [NW-1:0] rem_next;
    logic [RW-1:0] root_next;
    logic [NW-1:0] rem_reg;
    logic [RW-1:0] root_reg;

    assign rem_ext = TW'(rem_in);
    assign trial   = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));

    always_comb begin
        if (rem_ext >= trial) begin
            rem_next  = NW'(rem_ext - trial);
            root_next = root_in | (RW'(1) << BIT);
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

// File: hw/rtl/c2s_norm_cell.sv
// One binary step of the operand normaliser ahead of the CORDIC.
// Depends on c2s_pkg; instantiated by the top level.
`default_nettype none

module c2s_norm_cell #(
    parameter int SHIFT = 1,
    parameter bit RIGHT = 1'b0
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [c2s_pkg::TURN_BITS-1:0] p_in,
    input  wire logic [c2s_pkg::TURN_BITS-1:0] q_in,
    output logic      [c2s_pkg::TURN_BITS-1:0] p_out,
    output logic      [c2s_pkg::TURN_BITS-1:0] q_out
);

    import c2s_pkg::*;

    logic [TURN_BITS-1:0] both;
    logic                 hit;
    logic [TURN_BITS-1:0] p_next;
    logic [TURN_BITS-1:0] q_next;
    logic [TURN_BITS-1:0] p_reg;
    logic [TURN_BITS-1:0] q_reg;

    assign both = p_in | q_in;

    always_comb begin
        if (RIGHT) begin
            hit    = (both >> (59 + SHIFT)) != '0;
            p_next = hit ? (p_in >> SHIFT) : p_in;
            q_next = hit ? (q_in >> SHIFT) : q_in;
        end else begin
            hit    = (both >> (60 - SHIFT)) == '0;
            p_next = hit ? (p_in << SHIFT) : p_in;
            q_next = hit ? (q_in << SHIFT) : q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    assign p_out = p_reg;
    assign q_out = q_reg;

endmodule

`default_nettype wire

// File: hw/rtl/c2s_cordic_cell.sv
// One vectoring CORDIC rotation with its arctangent constant.
// Depends on c2s_pkg; instantiated by the top level.
`default_nettype none

module c2s_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [c2s_pkg::TURN_BITS-1:0] x_in,
    input  wire logic [c2s_pkg::TURN_BITS-1:0] y_in,
    input  wire logic [c2s_pkg::TURN_BITS-1:0] z_in,
    output logic      [c2s_pkg::TURN_BITS-1:0] x_out,
    output logic      [c2s_pkg::TURN_BITS-1:0] y_out,
    output logic      [c2s_pkg::TURN_BITS-1:0] z_out
);

    import c2s_pkg::*;

    localparam logic [TURN_BITS-1:0] ATAN = atan_entry(STAGE);

    logic [TURN_BITS-1:0] xs;
    logic [TURN_BITS-1:0] ys;
    logic [TURN_BITS-1:0] x_next;
    logic [TURN_BITS-1:0] y_next;
    logic [TURN_BITS-1:0] z_next;
    logic [TURN_BITS-1:0] x_reg;
    logic [TURN_BITS-1:0] y_reg;
    logic [TURN_BITS-1:0] z_reg;

    assign xs = x_in >> STAGE;
    assign ys = $unsigned($signed(y_in) >>> STAGE);

    always_comb begin
        if (!y_in[TURN_BITS-1]) begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

// File: test/tb_cartesian_to_spherical.sv
// Self-checking testbench for cartesian_to_spherical: a directed table, then random vectors
// over several zero_threshold settings, checked against a CORDIC predictor in this file.
// Depends on c2s_pkg and the RTL of the converter.
`default_nettype none

module tb_cartesian_to_spherical;
    import c2s_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PIPE_DEPTH     = 130;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        bit                           typed;
        out_word_t                    want;
    } vec_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_word_t                 s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_word_t                m_data;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    logic [63:0]     atan_turn_tab [CORDIC_STAGES];
    logic [15:0]     thr_now = '0;
    out_word_t       pending_sph [$];
    vec_row_t        dir_rows [$];
    bit              typed_q [$];
    out_word_t       typed_want_q [$];
    int unsigned     mismatches = 0;
    int unsigned     idle_cycles = 0;
    bit              no_idle = 1'b0;
    int unsigned     stall_left = 0;

    cartesian_to_spherical dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] isqrt_floor(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    // atan(q / p) in turns, 2^62 per turn, for p and q above zero
    function automatic logic [63:0] vector_atan(input logic [63:0] p, input logic [63:0] q);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] xs;
        logic [63:0] ys;
        while ((p | q) >= (64'd1 << 60)) begin
            p = p >> 1;
            q = q >> 1;
        end
        while ((p | q) < (64'd1 << 59)) begin
            p = p << 1;
            q = q << 1;
        end
        x = p;
        y = q;
        z = '0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >> i;
            ys = $unsigned($signed(y) >>> i);
            if (!y[63]) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_turn_tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_turn_tab[i];
            end
        end
        if (z[63]) begin
            return '0;
        end
        return (z > TURN_QUARTER) ? TURN_QUARTER : z;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] turns_to_units(input logic [63:0] a);
        logic [63:0] s;
        s = (a + (64'd1 << (61 - ANGLE_BITS))) >> (62 - ANGLE_BITS);
        return s[ANGLE_BITS-1:0];
    endfunction

    function automatic logic [63:0] coord_mag(input logic signed [COORD_BITS-1:0] v);
        return v[COORD_BITS-1] ? (64'd1 << COORD_BITS) - 64'($unsigned(v)) : 64'($unsigned(v));
    endfunction

    function automatic side_t coord_side(input logic signed [COORD_BITS-1:0] v,
                                         input logic [63:0] mag, input logic [15:0] thr);
        if (mag == 0 || mag < 64'(thr)) begin
            return SIDE_ZERO;
        end
        return v[COORD_BITS-1] ? SIDE_NEG : SIDE_POS;
    endfunction

    function automatic out_word_t spherical_of(input in_word_t w, input logic [15:0] thr);
        out_word_t    o;
        logic [63:0]  mx;
        logic [63:0]  my;
        logic [63:0]  mz;
        logic [63:0]  r;
        logic [63:0]  rho;
        logic [63:0]  a;
        logic [63:0]  pol;
        logic [63:0]  azi;
        logic [127:0] pl;
        logic [127:0] full;
        side_t        sx;
        side_t        sy;
        side_t        sz;
        mx = coord_mag(w.x_coord);
        my = coord_mag(w.y_coord);
        mz = coord_mag(w.z_coord);
        o  = '0;
        if ((mx | my | mz) == 0) begin
            o.undefined_flag = 1'b1;
            return o;
        end
        pl   = 128'(mx) * 128'(mx) + 128'(my) * 128'(my);
        full = pl + 128'(mz) * 128'(mz);
        r    = isqrt_floor(full);
        if (full - 128'(r) * 128'(r) > 128'(r)) begin
            r = r + 1;
        end
        sx = coord_side(w.x_coord, mx, thr);
        sy = coord_side(w.y_coord, my, thr);
        sz = coord_side(w.z_coord, mz, thr);
        if (sz == SIDE_ZERO) begin
            pol = TURN_QUARTER;
        end else begin
            rho = isqrt_floor(pl << 30);
            a   = (rho == 0) ? '0 : vector_atan(mz << 15, rho);
            pol = (sz == SIDE_POS) ? a : TURN_HALF - a;
        end
        if (sy == SIDE_ZERO) begin
            azi = (sx == SIDE_POS) ? TURN_HALF : '0;
        end else if (sx == SIDE_ZERO) begin
            azi = (sy == SIDE_POS) ? TURN_QUARTER : TURN_3QUARTER;
        end else begin
            a = vector_atan(mx, my);
            if (sx == SIDE_NEG && sy == SIDE_POS) begin
                azi = a;
            end else if (sx == SIDE_POS && sy == SIDE_POS) begin
                azi = TURN_HALF - a;
            end else if (sx == SIDE_POS) begin
                azi = TURN_HALF + a;
            end else begin
                azi = TURN_FULL - a;
            end
        end
        o.radius      = r[COORD_BITS-1:0];
        o.polar_angle = turns_to_units(pol);
        o.azimuth     = turns_to_units(azi);
        return o;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord(input logic [15:0] thr);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 32'($urandom_range(0, 300));
            2: v = -32'($urandom_range(0, 300));
            3: v = 32'(thr) + 32'($urandom_range(0, 2)) - 32'd1;
            4: v = -(32'(thr) + 32'($urandom_range(0, 2)) - 32'd1);
            5: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            6: v = 32'($signed($urandom_range(0, 200000)) - 100000);
            default: v = $urandom;
        endcase
        return $signed(v);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // check every word leaving, predict every word entering
    always @(posedge aclk) begin
        out_word_t want;
        bit        typed;
        out_word_t typed_want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_valid && s_ready) begin
                pending_sph.push_back(spherical_of(s_data, thr_now));
            end
            if (m_valid && m_ready) begin
                if (pending_sph.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: %p", m_data);
                    end
                end else begin
                    want       = pending_sph.pop_front();
                    typed      = typed_q.size() ? typed_q.pop_front() : 1'b0;
                    typed_want = typed_want_q.size() ? typed_want_q.pop_front() : want;
                    if (typed) begin
                        want = typed_want;
                    end
                    if (m_data.radius !== want.radius
                        || m_data.polar_angle !== want.polar_angle
                        || m_data.azimuth !== want.azimuth
                        || m_data.undefined_flag !== want.undefined_flag) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected r=%0d pol=%0d az=%0d u=%0b",
                                     want.radius, want.polar_angle, want.azimuth,
                                     want.undefined_flag);
                            $display("          actual   r=%0d pol=%0d az=%0d u=%0b",
                                     m_data.radius, m_data.polar_angle, m_data.azimuth,
                                     m_data.undefined_flag);
                        end
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_cartesian_to_spherical: errors");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        int r;
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else if (r < 96) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(20, 60);
            end
        end
    end

    task automatic send_vector(input in_word_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        forever begin
            @(negedge aclk);
            if (s_ready) begin
                break;
            end
        end
        @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_sph.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ZERO_THRESHOLD, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_now = value;
    endtask

    task automatic add_row(input int x, input int y, input int z, input bit typed,
                           input logic [31:0] r, input logic [15:0] pol,
                           input logic [15:0] az, input bit u);
        vec_row_t row;
        row.x     = x;
        row.y     = y;
        row.z     = z;
        row.typed = typed;
        row.want  = '{radius: r, polar_angle: pol, azimuth: az, undefined_flag: u};
        dir_rows.push_back(row);
    endtask

    initial begin
        logic [63:0]  rad;
        logic [63:0]  term;
        logic [127:0] num;
        int           e;
        in_word_t     w;
        logic [15:0]  phase_thr [6];

        atan_turn_tab[0] = TURN_EIGHTH;
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            rad = '0;
            for (int k = 0; k < 31; k++) begin
                e = i * (2 * k + 1);
                if (e > 60) begin
                    break;
                end
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                rad  = k[0] ? rad - term : rad + term;
            end
            num = (128'(rad) << 62) + 128'(PI_Q60);
            atan_turn_tab[i] = 64'(num / (128'(PI_Q60) * 2));
        end

        add_row(0, 0, 0, 1, 0, 0, 0, 1);
        add_row(0, 0, 5, 1, 5, 0, 0, 0);
        add_row(0, 0, -5, 1, 5, 16'd32768, 0, 0);
        add_row(3, 0, 0, 1, 3, 16'd16384, 16'd32768, 0);
        add_row(-3, 0, 0, 1, 3, 16'd16384, 0, 0);
        add_row(0, 4, 0, 1, 4, 16'd16384, 16'd16384, 0);
        add_row(0, -4, 0, 1, 4, 16'd16384, 16'd49152, 0);
        add_row(3, 4, 0, 0, 0, 0, 0, 0);
        add_row(-3, 4, 12, 0, 0, 0, 0, 0);
        add_row(3, -4, -12, 0, 0, 0, 0, 0);
        add_row(-3, -4, 7, 0, 0, 0, 0, 0);
        add_row(1, 1, 1, 0, 0, 0, 0, 0);
        add_row(-1, 0, 1, 0, 0, 0, 0, 0);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        add_row(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(-1, -1, -1, 0, 0, 0, 0, 0);
        add_row(123456789, -987654321, 55555, 0, 0, 0, 0, 0);

        phase_thr = '{16'hFFFF, 16'd0, 16'd1, 16'd5, 16'd250, 16'h0000};
        phase_thr[5] = 16'($urandom);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        write_threshold(16'd0);

        no_idle = 1'b1;
        foreach (dir_rows[i]) begin
            typed_q.push_back(dir_rows[i].typed);
            typed_want_q.push_back(dir_rows[i].want);
            w = '{x_coord: dir_rows[i].x, y_coord: dir_rows[i].y, z_coord: dir_rows[i].z};
            send_vector(w);
        end
        no_idle = 1'b0;

        for (int p = 0; p < 6; p++) begin
            drain_results();
            typed_q.delete();
            typed_want_q.delete();
            write_threshold(phase_thr[p]);
            for (int n = 0; n < 135; n++) begin
                if (n == 60) begin
                    no_idle = ($urandom_range(0, 1) == 1);
                end else if (n == 100) begin
                    no_idle = 1'b0;
                end
                w.x_coord = pick_coord(thr_now);
                w.y_coord = pick_coord(thr_now);
                w.z_coord = pick_coord(thr_now);
                send_vector(w);
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("tb_cartesian_to_spherical: clean");
        end else begin
            $display("tb_cartesian_to_spherical: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
